// ===== rtl/clbs_pkg.sv =====
// Shared types, constants and microprogram ROM for the character LCD bus sequencer.
`timescale 1ns / 1ps

package clbs_pkg;

    localparam int PC_W         = 6;
    localparam int HOLD_W       = 14;
    localparam int NIBBLE_SHIFT = 4;
    localparam int APB_ADDR_W   = 3;

    localparam logic REG_MODE_IDX = 1'b0;

    typedef enum logic [1:0] {
        CMD_BYTE,
        CMD_DATA,
        CMD_CURSOR,
        CMD_INIT
    } cmd_t;

    typedef enum logic [1:0] {
        SRC_ZERO,
        SRC_VALUE,
        SRC_POS,
        SRC_CONST
    } src_t;

    typedef enum logic [1:0] {
        NIB_FULL,
        NIB_HI,
        NIB_LO
    } nib_t;

    typedef enum logic [2:0] {
        H_ZERO,
        H_EN,
        H_LOW,
        H_SETTLE,
        H_CLEAR,
        H_POWER
    } hold_t;

    typedef enum logic [1:0] {
        J_NONE,
        J_MODE8,
        J_BAD
    } cond_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] value;
        logic [5:0] column;
        logic [2:0] row;
    } req_t;

    typedef struct packed {
        logic [7:0]        data_lines;
        logic              reg_select;
        logic              read_write;
        logic              enable;
        logic [HOLD_W-1:0] hold_us;
        logic              bad_position;
        logic              last;
    } phase_t;

    typedef struct packed {
        logic            emit;
        src_t            src;
        logic [7:0]      konst;
        nib_t            nib;
        logic            en;
        hold_t           hold;
        logic            last;
        logic            bad;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } uword_t;

    localparam logic [PC_W-1:0] ENTRY_BYTE  = 6'd0;
    localparam logic [PC_W-1:0] BYTE_LO     = 6'd3;
    localparam logic [PC_W-1:0] ENTRY_POS   = 6'd5;
    localparam logic [PC_W-1:0] POS_LO      = 6'd9;
    localparam logic [PC_W-1:0] ADDR_ERR    = 6'd11;
    localparam logic [PC_W-1:0] ENTRY_INIT  = 6'd12;
    localparam logic [PC_W-1:0] INIT8_START = 6'd37;

    function automatic logic [HOLD_W-1:0] hold_value(input hold_t sel);
        logic [HOLD_W-1:0] h;
        unique case (sel)
            H_EN:     h = 14'd40;
            H_LOW:    h = 14'd100;
            H_SETTLE: h = 14'd200;
            H_CLEAR:  h = 14'd1600;
            H_POWER:  h = 14'd15000;
            default:  h = '0;
        endcase
        return h;
    endfunction

    function automatic logic [7:0] row_base(input logic [1:0] row);
        logic [7:0] b;
        unique case (row)
            2'd0:    b = 8'h80;
            2'd1:    b = 8'hC0;
            2'd2:    b = 8'h90;
            default: b = 8'hD0;
        endcase
        return b;
    endfunction

    function automatic uword_t op(input src_t src, input logic [7:0] konst, input nib_t nib,
                                  input logic en, input hold_t hold, input logic last);
        uword_t w;
        w        = '0;
        w.emit   = 1'b1;
        w.src    = src;
        w.konst  = konst;
        w.nib    = nib;
        w.en     = en;
        w.hold   = hold;
        w.last   = last;
        w.cond   = J_NONE;
        return w;
    endfunction

    function automatic uword_t jmp(input cond_t cond, input logic [PC_W-1:0] target);
        uword_t w;
        w        = '0;
        w.cond   = cond;
        w.target = target;
        return w;
    endfunction

    function automatic uword_t rom_word(input logic [PC_W-1:0] pc);
        uword_t w;
        w = '0;
        unique case (pc)
            // command / data byte
            6'd0:  w = jmp(J_MODE8, BYTE_LO);
            6'd1:  w = op(SRC_VALUE, 8'h00, NIB_HI, 1'b1, H_EN, 1'b0);
            6'd2:  w = op(SRC_VALUE, 8'h00, NIB_HI, 1'b0, H_LOW, 1'b0);
            6'd3:  w = op(SRC_VALUE, 8'h00, NIB_LO, 1'b1, H_EN, 1'b0);
            6'd4:  w = op(SRC_VALUE, 8'h00, NIB_LO, 1'b0, H_LOW, 1'b1);
            // cursor position
            6'd5:  w = jmp(J_BAD, ADDR_ERR);
            6'd6:  w = jmp(J_MODE8, POS_LO);
            6'd7:  w = op(SRC_POS, 8'h00, NIB_HI, 1'b1, H_EN, 1'b0);
            6'd8:  w = op(SRC_POS, 8'h00, NIB_HI, 1'b0, H_LOW, 1'b0);
            6'd9:  w = op(SRC_POS, 8'h00, NIB_LO, 1'b1, H_EN, 1'b0);
            6'd10: w = op(SRC_POS, 8'h00, NIB_LO, 1'b0, H_SETTLE, 1'b1);
            6'd11:
            begin
                w     = op(SRC_ZERO, 8'h00, NIB_FULL, 1'b0, H_ZERO, 1'b1);
                w.bad = 1'b1;
            end
            // init: power-up wait, then the mode's table
            6'd12:
            begin
                w        = op(SRC_ZERO, 8'h00, NIB_FULL, 1'b0, H_POWER, 1'b0);
                w.cond   = J_MODE8;
                w.target = INIT8_START;
            end
            6'd13: w = op(SRC_CONST, 8'h33, NIB_HI, 1'b1, H_EN, 1'b0);
            6'd14: w = op(SRC_CONST, 8'h33, NIB_HI, 1'b0, H_LOW, 1'b0);
            6'd15: w = op(SRC_CONST, 8'h33, NIB_LO, 1'b1, H_EN, 1'b0);
            6'd16: w = op(SRC_CONST, 8'h33, NIB_LO, 1'b0, H_SETTLE, 1'b0);
            6'd17: w = op(SRC_CONST, 8'h32, NIB_HI, 1'b1, H_EN, 1'b0);
            6'd18: w = op(SRC_CONST, 8'h32, NIB_HI, 1'b0, H_LOW, 1'b0);
            6'd19: w = op(SRC_CONST, 8'h32, NIB_LO, 1'b1, H_EN, 1'b0);
            6'd20: w = op(SRC_CONST, 8'h32, NIB_LO, 1'b0, H_SETTLE, 1'b0);
            6'd21: w = op(SRC_CONST, 8'h28, NIB_HI, 1'b1, H_EN, 1'b0);
            6'd22: w = op(SRC_CONST, 8'h28, NIB_HI, 1'b0, H_LOW, 1'b0);
            6'd23: w = op(SRC_CONST, 8'h28, NIB_LO, 1'b1, H_EN, 1'b0);
            6'd24: w = op(SRC_CONST, 8'h28, NIB_LO, 1'b0, H_SETTLE, 1'b0);
            6'd25: w = op(SRC_CONST, 8'h0E, NIB_HI, 1'b1, H_EN, 1'b0);
            6'd26: w = op(SRC_CONST, 8'h0E, NIB_HI, 1'b0, H_LOW, 1'b0);
            6'd27: w = op(SRC_CONST, 8'h0E, NIB_LO, 1'b1, H_EN, 1'b0);
            6'd28: w = op(SRC_CONST, 8'h0E, NIB_LO, 1'b0, H_SETTLE, 1'b0);
            6'd29: w = op(SRC_CONST, 8'h06, NIB_HI, 1'b1, H_EN, 1'b0);
            6'd30: w = op(SRC_CONST, 8'h06, NIB_HI, 1'b0, H_LOW, 1'b0);
            6'd31: w = op(SRC_CONST, 8'h06, NIB_LO, 1'b1, H_EN, 1'b0);
            6'd32: w = op(SRC_CONST, 8'h06, NIB_LO, 1'b0, H_SETTLE, 1'b0);
            6'd33: w = op(SRC_CONST, 8'h01, NIB_HI, 1'b1, H_EN, 1'b0);
            6'd34: w = op(SRC_CONST, 8'h01, NIB_HI, 1'b0, H_LOW, 1'b0);
            6'd35: w = op(SRC_CONST, 8'h01, NIB_LO, 1'b1, H_EN, 1'b0);
            6'd36: w = op(SRC_CONST, 8'h01, NIB_LO, 1'b0, H_CLEAR, 1'b1);
            6'd37: w = op(SRC_CONST, 8'h38, NIB_FULL, 1'b1, H_EN, 1'b0);
            6'd38: w = op(SRC_CONST, 8'h38, NIB_FULL, 1'b0, H_SETTLE, 1'b0);
            6'd39: w = op(SRC_CONST, 8'h0E, NIB_FULL, 1'b1, H_EN, 1'b0);
            6'd40: w = op(SRC_CONST, 8'h0E, NIB_FULL, 1'b0, H_SETTLE, 1'b0);
            6'd41: w = op(SRC_CONST, 8'h06, NIB_FULL, 1'b1, H_EN, 1'b0);
            6'd42: w = op(SRC_CONST, 8'h06, NIB_FULL, 1'b0, H_SETTLE, 1'b0);
            6'd43: w = op(SRC_CONST, 8'h01, NIB_FULL, 1'b1, H_EN, 1'b0);
            6'd44: w = op(SRC_CONST, 8'h01, NIB_FULL, 1'b0, H_CLEAR, 1'b1);
            default: w = op(SRC_ZERO, 8'h00, NIB_FULL, 1'b0, H_ZERO, 1'b1);
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/clbs_sequencer.sv =====
// Microcoded step sequencer and phase datapath for the LCD bus.
`timescale 1ns / 1ps

module clbs_sequencer (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  clbs_pkg::req_t                  req,
    input  logic                            four_bit,
    input  logic                            slot_free,
    output logic                            busy,
    output logic                            phase_load,
    output clbs_pkg::phase_t                phase
);

    logic                        busy_reg, busy_next;
    logic [clbs_pkg::PC_W-1:0]   pc_reg, pc_next;
    logic                        rs_reg;
    logic                        bad_reg;
    logic [7:0]                  value_reg;
    logic [7:0]                  addr_reg;

    clbs_pkg::uword_t            uw;
    logic                        go;
    logic [7:0]                  byte_sel;
    logic [7:0]                  hi_bus;
    logic [7:0]                  lo_bus;
    logic [7:0]                  data_sel;

    assign uw         = clbs_pkg::rom_word(pc_reg);
    assign go         = busy_reg && (!uw.emit || slot_free);
    assign phase_load = busy_reg && uw.emit && slot_free;
    assign busy       = busy_reg;

    always_comb
    begin
        busy_next = busy_reg;
        pc_next   = pc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            unique case (req.cmd)
                clbs_pkg::CMD_BYTE,
                clbs_pkg::CMD_DATA:   pc_next = clbs_pkg::ENTRY_BYTE;
                clbs_pkg::CMD_CURSOR: pc_next = clbs_pkg::ENTRY_POS;
                default:              pc_next = clbs_pkg::ENTRY_INIT;
            endcase
        end
        else if (go)
        begin
            if (uw.emit && uw.last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                case (uw.cond)
                    clbs_pkg::J_MODE8: pc_next = four_bit ? pc_reg + 6'd1 : uw.target;
                    clbs_pkg::J_BAD:   pc_next = bad_reg ? uw.target : pc_reg + 6'd1;
                    default:           pc_next = pc_reg + 6'd1;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pc_reg   <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            pc_reg   <= pc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rs_reg    <= (req.cmd == clbs_pkg::CMD_DATA);
            bad_reg   <= req.row[2] | (|req.column[5:4]);
            value_reg <= req.value;
            addr_reg  <= clbs_pkg::row_base(req.row[1:0]) + {4'b0, req.column[3:0]};
        end
    end

    always_comb
    begin
        case (uw.src)
            clbs_pkg::SRC_VALUE: byte_sel = value_reg;
            clbs_pkg::SRC_POS:   byte_sel = addr_reg;
            clbs_pkg::SRC_CONST: byte_sel = uw.konst;
            default:             byte_sel = 8'h00;
        endcase
    end

    assign hi_bus = 8'({4'b0, byte_sel[7:4]} << clbs_pkg::NIBBLE_SHIFT);
    assign lo_bus = 8'({4'b0, byte_sel[3:0]} << clbs_pkg::NIBBLE_SHIFT);

    always_comb
    begin
        case (uw.nib)
            clbs_pkg::NIB_HI: data_sel = hi_bus;
            clbs_pkg::NIB_LO: data_sel = four_bit ? lo_bus : byte_sel;
            default:          data_sel = byte_sel;
        endcase
    end

    always_comb
    begin
        phase.data_lines   = data_sel;
        phase.reg_select   = rs_reg & ~uw.bad;
        phase.read_write   = 1'b0;
        phase.enable       = uw.en;
        phase.hold_us      = clbs_pkg::hold_value(uw.hold);
        phase.bad_position = uw.bad;
        phase.last         = uw.last;
    end

endmodule

// ===== rtl/char_lcd_bus_sequencer.sv =====
// Character LCD bus sequencer top level: stream ports, APB mode register, output register.
// Entry: a request's jump steps run first; its first phase is then registered for output.
// Throughput: one pin phase per cycle from the microprogram ROM while the output is not
// stalled; a request takes its phase count plus up to two jump steps.
// A new request is accepted the cycle after the previous one issues its last phase.
// Reset: asynchronous, clears the mode register to 8-bit and idles the sequencer.
`timescale 1ns / 1ps

module char_lcd_bus_sequencer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [23:0]                       s_axis_tdata,  // value, column, row, zero pad
    input  logic [1:0]                        s_axis_tuser,  // cmd
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [23:0]                       m_axis_tdata,  // data_lines, read_write, enable, hold_us
    output logic [1:0]                        m_axis_tuser,  // reg_select, bad_position
    output logic                              m_axis_tlast,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [clbs_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    logic               mode_reg, mode_next;
    logic               out_valid_reg, out_valid_next;
    clbs_pkg::phase_t   out_reg;
    clbs_pkg::phase_t   phase;
    clbs_pkg::req_t     req;
    logic               busy;
    logic               phase_load;
    logic               slot_free;
    logic               start;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == clbs_pkg::REG_MODE_IDX);
    assign prdata = (paddr[2] == clbs_pkg::REG_MODE_IDX) ? {31'b0, mode_reg} : 32'b0;

    always_comb
    begin
        mode_next = mode_reg;
        if (cfg_wr)
        begin
            mode_next = pwdata[0];
        end
    end

    assign req.cmd    = clbs_pkg::cmd_t'(s_axis_tuser);
    assign req.value  = s_axis_tdata[7:0];
    assign req.column = s_axis_tdata[13:8];
    assign req.row    = s_axis_tdata[16:14];

    assign s_axis_tready = !busy;
    assign start         = s_axis_tvalid && s_axis_tready;
    assign slot_free     = !out_valid_reg || m_axis_tready;

    clbs_sequencer u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .req        (req),
        .four_bit   (mode_reg),
        .slot_free  (slot_free),
        .busy       (busy),
        .phase_load (phase_load),
        .phase      (phase)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (phase_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (phase_load)
        begin
            out_reg <= phase;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.hold_us, out_reg.enable, out_reg.read_write,
                            out_reg.data_lines};
    assign m_axis_tuser  = {out_reg.bad_position, out_reg.reg_select};
    assign m_axis_tlast  = out_reg.last;

endmodule

// ===== rtl/clbs_checker.sv =====
// Port-level assertions for the LCD bus sequencer, bound to the top level.
`timescale 1ns / 1ps

module clbs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    a_bad_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
        else $error("error result not marked last");

    a_bad_is_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> (m_axis_tdata == 24'd0) && !m_axis_tuser[0])
        else $error("error result drives the bus");

    a_write_only: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !m_axis_tdata[8])
        else $error("read_write asserted");

    a_en_pulse_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[9] |-> (m_axis_tdata[23:10] == 14'd40) && !m_axis_tlast)
        else $error("EN high phase has wrong hold or ends request");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("stalled transfer changed");

endmodule

bind char_lcd_bus_sequencer clbs_checker u_clbs_checker (.*);

// ===== bench/tb.sv =====
// Self-checking bench for the character LCD bus sequencer: directed table, then random requests.
`timescale 1ns / 1ps

module tb;
    import clbs_pkg::*;

    localparam logic [HOLD_W-1:0]     EN_HIGH_US      = 14'd40;
    localparam logic [HOLD_W-1:0]     EN_LOW_US       = 14'd100;
    localparam logic [HOLD_W-1:0]     SETTLE_US       = 14'd100;
    localparam logic [HOLD_W-1:0]     CLEAR_SETTLE_US = 14'd1500;
    localparam logic [HOLD_W-1:0]     POWER_WAIT_US   = 14'd15000;
    localparam logic [APB_ADDR_W-1:0] MODE_ADDR       = {REG_MODE_IDX, 2'b00};
    localparam int                    SETTLE_CYCLES   = 8;
    localparam int                    ITEMS_PER_PHASE = 70;

    localparam logic [3:0][7:0] ROW_BASE  = {8'hD0, 8'h90, 8'hC0, 8'h80};
    localparam logic [3:0][7:0] INIT8_SEQ = {8'h01, 8'h06, 8'h0E, 8'h38};
    localparam logic [5:0][7:0] INIT4_SEQ = {8'h01, 8'h06, 8'h0E, 8'h28, 8'h32, 8'h33};

    localparam phase_t BAD_POS_PHASE = '{data_lines: 8'h00, reg_select: 1'b0, read_write: 1'b0,
                                         enable: 1'b0, hold_us: '0, bad_position: 1'b1,
                                         last: 1'b1};

    typedef struct packed {
        logic   mode;
        req_t   ask;
        logic   typed;
        phase_t want;
    } script_row_t;

    localparam script_row_t SCRIPT [19] = '{
        '{1'b0, '{CMD_INIT,   8'h00, 6'd0,  3'd0}, 1'b0, '0},
        '{1'b0, '{CMD_BYTE,   8'h00, 6'd0,  3'd0}, 1'b0, '0},
        '{1'b0, '{CMD_BYTE,   8'hFF, 6'd0,  3'd0}, 1'b0, '0},
        '{1'b0, '{CMD_DATA,   8'hA5, 6'd63, 3'd7}, 1'b0, '0},
        '{1'b0, '{CMD_DATA,   8'h5A, 6'd0,  3'd0}, 1'b0, '0},
        '{1'b0, '{CMD_CURSOR, 8'h00, 6'd0,  3'd0}, 1'b0, '0},
        '{1'b0, '{CMD_CURSOR, 8'h00, 6'd15, 3'd3}, 1'b0, '0},
        '{1'b0, '{CMD_CURSOR, 8'h00, 6'd0,  3'd4}, 1'b1, BAD_POS_PHASE},
        '{1'b0, '{CMD_CURSOR, 8'h00, 6'd16, 3'd0}, 1'b1, BAD_POS_PHASE},
        '{1'b0, '{CMD_CURSOR, 8'hFF, 6'd63, 3'd7}, 1'b1, BAD_POS_PHASE},
        '{1'b1, '{CMD_INIT,   8'h00, 6'd0,  3'd0}, 1'b0, '0},
        '{1'b1, '{CMD_BYTE,   8'hFF, 6'd0,  3'd0}, 1'b0, '0},
        '{1'b1, '{CMD_DATA,   8'h00, 6'd0,  3'd0}, 1'b0, '0},
        '{1'b1, '{CMD_DATA,   8'h3C, 6'd0,  3'd0}, 1'b0, '0},
        '{1'b1, '{CMD_CURSOR, 8'h00, 6'd15, 3'd1}, 1'b0, '0},
        '{1'b1, '{CMD_CURSOR, 8'h00, 6'd7,  3'd2}, 1'b0, '0},
        '{1'b1, '{CMD_CURSOR, 8'h00, 6'd15, 3'd4}, 1'b1, BAD_POS_PHASE},
        '{1'b1, '{CMD_CURSOR, 8'h00, 6'd63, 3'd3}, 1'b1, BAD_POS_PHASE},
        '{1'b0, '{CMD_BYTE,   8'h81, 6'd0,  3'd0}, 1'b0, '0}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [23:0]           s_axis_tdata;   // value, column, row, zero pad
    logic [1:0]            s_axis_tuser;   // cmd
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [23:0]           m_axis_tdata;   // data_lines, read_write, enable, hold_us
    logic [1:0]            m_axis_tuser;   // reg_select, bad_position
    logic                  m_axis_tlast;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    phase_t pin_phase_q[$];
    logic   four_bit;
    int     failures;
    int     gap_odds;
    int     stall_odds;
    int     stall_left;

    char_lcd_bus_sequencer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic void add_phase(input logic [7:0] lines, input logic rs, input logic en,
                                      input logic [HOLD_W-1:0] hold, input logic bad,
                                      input logic fin);
        phase_t p;
        p.data_lines   = lines;
        p.reg_select   = rs;
        p.read_write   = 1'b0;
        p.enable       = en;
        p.hold_us      = hold;
        p.bad_position = bad;
        p.last         = fin;
        pin_phase_q.push_back(p);
    endfunction

    function automatic void add_pulse(input logic [7:0] lines, input logic rs,
                                      input logic [HOLD_W-1:0] low_hold, input logic fin);
        add_phase(lines, rs, 1'b1, EN_HIGH_US, 1'b0, 1'b0);
        add_phase(lines, rs, 1'b0, low_hold, 1'b0, fin);
    endfunction

    function automatic void add_byte(input logic [7:0] b, input logic rs,
                                     input logic [HOLD_W-1:0] extra, input logic fin);
        logic [7:0] hi;
        logic [7:0] lo;
        hi = {4'b0, b[7:4]} << NIBBLE_SHIFT;
        lo = {4'b0, b[3:0]} << NIBBLE_SHIFT;
        if (four_bit)
        begin
            add_pulse(hi, rs, EN_LOW_US, 1'b0);
            add_pulse(lo, rs, EN_LOW_US + extra, fin);
        end
        else
        begin
            add_pulse(b, rs, EN_LOW_US + extra, fin);
        end
    endfunction

    function automatic void predict_request(input req_t r);
        case (r.cmd)
            CMD_BYTE:
                add_byte(r.value, 1'b0, '0, 1'b1);
            CMD_DATA:
                add_byte(r.value, 1'b1, '0, 1'b1);
            CMD_CURSOR:
                if (r.row > 3'd3 || r.column > 6'd15)
                    add_phase(8'h00, 1'b0, 1'b0, '0, 1'b1, 1'b1);
                else
                    add_byte(ROW_BASE[r.row[1:0]] + {2'b0, r.column}, 1'b0, SETTLE_US, 1'b1);
            default:
            begin
                add_phase(8'h00, 1'b0, 1'b0, POWER_WAIT_US, 1'b0, 1'b0);
                if (four_bit)
                begin
                    for (int i = 0; i < 6; i++)
                        add_byte(INIT4_SEQ[i], 1'b0, (i == 5) ? CLEAR_SETTLE_US : SETTLE_US,
                                 i == 5);
                end
                else
                begin
                    for (int i = 0; i < 4; i++)
                        add_byte(INIT8_SEQ[i], 1'b0, (i == 3) ? CLEAR_SETTLE_US : SETTLE_US,
                                 i == 3);
                end
            end
        endcase
    endfunction

    function automatic req_t random_request();
        req_t        r;
        int unsigned pick;
        pick     = $urandom_range(99, 0);
        r.value  = 8'($urandom);
        r.column = 6'($urandom);
        r.row    = 3'($urandom);
        if (pick < 35)
            r.cmd = CMD_BYTE;
        else if (pick < 70)
            r.cmd = CMD_DATA;
        else if (pick < 92)
        begin
            r.cmd = CMD_CURSOR;
            // mostly on-screen positions, the rest anywhere in the field range
            if ($urandom_range(4, 0) != 0)
            begin
                r.row    = 3'($urandom_range(3, 0));
                r.column = 6'($urandom_range(15, 0));
            end
        end
        else
            r.cmd = CMD_INIT;
        return r;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endfunction

    function automatic void check_phase();
        phase_t want;
        if (pin_phase_q.size() == 0)
        begin
            $error("pin phase transfer with nothing expected");
            failures++;
        end
        else
        begin
            want = pin_phase_q.pop_front();
            check_field("data_lines", want.data_lines, m_axis_tdata[7:0]);
            check_field("read_write", want.read_write, m_axis_tdata[8]);
            check_field("enable", want.enable, m_axis_tdata[9]);
            check_field("hold_us", want.hold_us, m_axis_tdata[23:10]);
            check_field("reg_select", want.reg_select, m_axis_tuser[0]);
            check_field("bad_position", want.bad_position, m_axis_tuser[1]);
            check_field("last", want.last, m_axis_tlast);
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            check_phase();
        if (stall_left > 0)
        begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (stall_odds > 0 && $urandom_range(7, 0) < stall_odds)
        begin
            stall_left    <= $urandom_range(3, 0);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    task automatic send_request(input req_t r);
        int gap;
        if (gap_odds > 0 && $urandom_range(7, 0) < gap_odds)
        begin
            gap = $urandom_range(4, 1);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, r.row, r.column, r.value};
        s_axis_tuser  <= r.cmd;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pin_phase_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write the mode register, then read it back
    task automatic set_bus_mode(input logic four);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MODE_ADDR;
        pwdata  <= {31'b0, four};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        four_bit = four;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        check_field("four_bit_mode", four, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial
    begin
        req_t r;
        logic next_mode;
        failures      = 0;
        four_bit      = 1'b0;
        gap_odds      = 0;
        stall_odds    = 0;
        stall_left    = 0;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        m_axis_tready <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gap_odds   = 2;
        stall_odds = 2;
        for (int i = 0; i < $size(SCRIPT); i++)
        begin
            if (SCRIPT[i].mode != four_bit)
            begin
                drain_results();
                set_bus_mode(SCRIPT[i].mode);
            end
            send_request(SCRIPT[i].ask);
            if (SCRIPT[i].typed)
                pin_phase_q.push_back(SCRIPT[i].want);
            else
                predict_request(SCRIPT[i].ask);
        end

        // phase 2 runs without idling, phase 4 closes the run without idling
        for (int ph = 0; ph < 5; ph++)
        begin
            drain_results();
            if (ph == 2)
                next_mode = 1'($urandom_range(1, 0));
            else
                next_mode = (ph % 2 == 0);
            set_bus_mode(next_mode);
            gap_odds   = (ph == 2 || ph == 4) ? 0 : ph + 2;
            stall_odds = (ph == 2 || ph == 4) ? 0 : 5 - ph;
            repeat (ITEMS_PER_PHASE)
            begin
                r = random_request();
                send_request(r);
                predict_request(r);
            end
        end

        drain_results();
        if (failures == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/clbs_pkg.sv
rtl/clbs_sequencer.sv
rtl/char_lcd_bus_sequencer.sv
rtl/clbs_checker.sv
bench/tb.sv
